@@ hw/rtl/cpbp_pkg.sv @@
package cpbp_pkg;

  // Widest element word the block handles.
  localparam int unsigned MaxWordBits = 32;

  // Result queue depth; an item may produce two results.
  localparam int unsigned FifoDepth = 4;

  // Input item kinds carried on the slave-side tuser.
  typedef enum logic {
    OpAnalyze = 1'b0,
    OpPack    = 1'b1
  } op_e;

  // Configured element widths.
  typedef enum logic [1:0] {
    Width8  = 2'd0,
    Width16 = 2'd1,
    Width32 = 2'd2
  } width_mode_e;

  // Result word kinds carried on the master-side tuser.
  typedef enum logic [1:0] {
    KindCount   = 2'd0,
    KindCommon  = 2'd1,
    KindPayload = 2'd2
  } kind_e;

  typedef struct packed {
    logic [31:0] word;
    kind_e       kind;
    logic        last;
  } result_t;

  // Results produced by one item; a single result always sits in first.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } emit_t;

  // Element width in bits for a width mode; undefined codes act as 32 bits.
  function automatic logic [5:0] word_bits(input logic [1:0] mode);
    logic [5:0] w;
    case (mode)
      Width8:  w = 6'd8;
      Width16: w = 6'd16;
      default: w = 6'd32;
    endcase
    if (w > 6'(MaxWordBits)) begin
      w = 6'(MaxWordBits);
    end
    return w;
  endfunction

  // Mask of the n low bits; 32 or more gives all ones.
  function automatic logic [31:0] low_mask(input logic [5:0] n);
    logic [31:0] m;
    if (n >= 6'd32) begin
      m = '1;
    end else begin
      m = (32'd1 << n) - 32'd1;
    end
    return m;
  endfunction

endpackage

@@ hw/rtl/cpbp_core.sv @@
module cpbp_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_wen_i,
  input  logic [1:0]          cfg_wdata_i,
  input  logic                item_valid_i,
  input  logic                opcode_i,
  input  logic [31:0]         value_i,
  input  logic                last_i,
  output cpbp_pkg::emit_t     emit_o
);
  import cpbp_pkg::*;

  logic [1:0]  mode_q;
  logic [31:0] and_q, and_d;
  logic [31:0] or_q, or_d;
  logic        seen_q, seen_d;
  logic [5:0]  ubc_q, ubc_d;
  logic [31:0] acc_q, acc_d;
  logic [5:0]  fr_q, fr_d;

  logic [5:0]  w;
  logic [31:0] wmask;
  logic [31:0] v;
  logic [31:0] diff;
  logic [5:0]  nb_an;
  logic [5:0]  nb;
  logic [5:0]  fr;
  logic [5:0]  s;
  logic [31:0] vv;
  logic [31:0] acc;
  result_t     res;

  // Width register; the user must write it only while the block is idle, as the block does not enforce it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= Width32;
    end else if (cfg_wen_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  assign w     = word_bits(mode_q);
  assign wmask = low_mask(w);
  assign v     = value_i & wmask;

  // Bits that differ among the values; the unique count is the top one's position.
  always_comb begin
    diff  = (and_d ^ or_d) & wmask;
    nb_an = '0;
    for (int i = 0; i < 32; i++) begin
      if (diff[i]) begin
        nb_an = 6'(i + 1);
      end
    end
  end

  // One item's full update: analyze fold and headers, or pack and split.
  always_comb begin
    and_d  = and_q;
    or_d   = or_q;
    seen_d = seen_q;
    ubc_d  = ubc_q;
    acc_d  = acc_q;
    fr_d   = fr_q;
    emit_o = '0;
    nb     = (ubc_q > w) ? w : ubc_q;
    fr     = (fr_q == 6'd0 || fr_q > w) ? w : fr_q;
    s      = nb - fr;
    vv     = v & low_mask(nb);
    acc    = acc_q & wmask;
    res    = '0;

    if (item_valid_i && opcode_i == OpAnalyze) begin
      if (!seen_q) begin
        and_d = v;
        or_d  = v;
      end else begin
        and_d = and_q & v;
        or_d  = or_q | v;
      end
      seen_d = 1'b1;
      if (last_i) begin
        emit_o.count        = 2'd2;
        emit_o.first.word   = 32'(nb_an);
        emit_o.first.kind   = KindCount;
        emit_o.first.last   = 1'b0;
        emit_o.second.word  = and_d & wmask & ~low_mask(nb_an);
        emit_o.second.kind  = KindCommon;
        emit_o.second.last  = (nb_an == 6'd0);
        ubc_d  = nb_an;
        seen_d = 1'b0;
        acc_d  = '0;
        fr_d   = w;
      end
    end else if (item_valid_i && nb != 6'd0) begin
      if (nb <= fr) begin
        // Value fits in the current word.
        acc = acc | ((vv << (fr - nb)) & wmask);
        fr  = fr - nb;
        if (fr == 6'd0) begin
          res.word     = acc;
          res.kind     = KindPayload;
          res.last     = last_i;
          emit_o.count = 2'd1;
          emit_o.first = res;
          acc          = '0;
          fr           = w;
        end
      end else begin
        // Value straddles the word boundary: close this word, carry the rest.
        res.word     = acc | (vv >> s);
        res.kind     = KindPayload;
        res.last     = 1'b0;
        emit_o.count = 2'd1;
        emit_o.first = res;
        acc          = (vv << (w - s)) & wmask;
        fr           = w - s;
      end
      // Flush a partly filled word at the end of the pass.
      if (last_i && fr < w) begin
        res.word = acc;
        res.kind = KindPayload;
        res.last = 1'b1;
        if (emit_o.count == 2'd0) begin
          emit_o.first = res;
          emit_o.count = 2'd1;
        end else begin
          emit_o.second = res;
          emit_o.count  = 2'd2;
        end
        acc = '0;
        fr  = w;
      end
      acc_d = acc;
      fr_d  = fr;
    end
  end

  // Encoder state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      and_q  <= '0;
      or_q   <= '0;
      seen_q <= 1'b0;
      ubc_q  <= '0;
      acc_q  <= '0;
      fr_q   <= 6'(MaxWordBits);
    end else begin
      and_q  <= and_d;
      or_q   <= or_d;
      seen_q <= seen_d;
      ubc_q  <= ubc_d;
      acc_q  <= acc_d;
      fr_q   <= fr_d;
    end
  end

endmodule

@@ hw/rtl/cpbp_fifo.sv @@
module cpbp_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cpbp_pkg::emit_t   emit_i,
  output logic              room_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output cpbp_pkg::result_t out_o
);
  import cpbp_pkg::*;

  localparam int unsigned PtrW = $clog2(FifoDepth);
  localparam int unsigned CntW = PtrW + 1;

  result_t         mem [FifoDepth];
  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != '0);
  assign out_o       = mem[rd_q];
  // Room for the two results one item may produce.
  assign room_o      = (cnt_q <= CntW'(FifoDepth - 2));

  assign wr_d  = wr_q + PtrW'(emit_i.count);
  assign rd_d  = rd_q + PtrW'(pop);
  assign cnt_d = cnt_q + CntW'(emit_i.count) - CntW'(pop);

  // Result storage, written with up to two entries per cycle.
  always_ff @(posedge clk_i) begin
    if (emit_i.count != 2'd0) begin
      mem[wr_q] <= emit_i.first;
    end
    if (emit_i.count == 2'd2) begin
      mem[wr_q + PtrW'(1)] <= emit_i.second;
    end
  end

  // Queue pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

@@ hw/rtl/common_prefix_bit_packer_top.sv @@
// Common-prefix bit packer. Send the array once with tuser=0 (analyze) and tlast on its
// final value: the block returns two header words, the count of unique low bits and the
// shared prefix value. Send the same values again with tuser=1 (pack): the unique bits
// come out packed MSB-first into words of the configured width (8, 16 or 32 bits), the
// last partial word zero-padded, tlast on the final word. Each item is processed in the
// cycle it is accepted and its results are written into the result queue; an item is taken
// every cycle while the four-entry result queue has room for two results, so the sustained
// rate is one item per cycle, bounded by m_axis_tready_i and the one-word-per-cycle output
// port when an item yields two words (the headers, or a split value ending the pack pass).
// Write the width register only while no transfer is in flight.
module common_prefix_bit_packer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_wen_i,
  input  logic [1:0]  cfg_wdata_i,    // width_mode
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i, // [31:0] value
  input  logic        s_axis_tlast_i, // last_of_pass
  input  logic [0:0]  s_axis_tuser_i, // [0] opcode
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o, // [31:0] word
  output logic        m_axis_tlast_o, // last
  output logic [1:0]  m_axis_tuser_o  // [1:0] kind
);
  import cpbp_pkg::*;

  emit_t   emit;
  result_t res;
  logic    accept;

  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  // Encoder: state update and results for each accepted transfer.
  cpbp_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_wen_i    (cfg_wen_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .item_valid_i (accept),
    .opcode_i     (s_axis_tuser_i[0]),
    .value_i      (s_axis_tdata_i),
    .last_i       (s_axis_tlast_i),
    .emit_o       (emit)
  );

  // Result queue decouples the output side from the input side.
  cpbp_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .emit_i      (emit),
    .room_o      (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_o       (res)
  );

  assign m_axis_tdata_o = res.word;
  assign m_axis_tuser_o = res.kind;
  assign m_axis_tlast_o = res.last;

endmodule
